[design/sha1s_pkg.sv]
// Shared types and constants for the SHA-1 stream hash block.
package sha1s_pkg;

    localparam int WordW     = 32;
    localparam int ByteW     = 8;
    localparam int CountW    = 61;
    localparam int RoundW    = 7;
    localparam int PosW      = 6;
    localparam int IdxW      = 3;
    localparam int LenW      = 64;
    localparam int NumChain  = 5;
    localparam int NumSched  = 16;
    localparam int NumRounds = 80;

    localparam logic [RoundW-1:0] LastRound  = RoundW'(NumRounds - 1);
    localparam logic [RoundW-1:0] EarlyLimit = RoundW'(NumSched);
    localparam logic [PosW-1:0]   LastPos    = '1;
    localparam logic [PosW-1:0]   LenPos     = PosW'(56);
    localparam logic [IdxW-1:0]   LastIdx    = IdxW'(NumChain - 1);
    localparam logic [ByteW-1:0]  PadByte    = 8'h80;

    localparam logic [NumChain-1:0][WordW-1:0] IvWords = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WordW-1:0] K0 = 32'h5A827999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             byte_valid;
        logic             end_of_message;
    } req_t;

    typedef struct packed {
        logic [WordW-1:0] digest_word;
        logic [IdxW-1:0]  word_index;
        logic             last_word;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_A,
        PH_MAJORITY,
        PH_PARITY_B
    } phase_t;

    // Control of the message schedule window.
    typedef struct packed {
        logic             we;
        logic [PosW-1:0]  pos;
        logic [ByteW-1:0] data;
        logic             step;
        logic             early;
    } sched_ctrl_t;

    // Control of the shared round unit and the chaining words.
    typedef struct packed {
        logic   load;
        logic   step;
        logic   fold;
        logic   restore;
        phase_t phase;
    } round_ctrl_t;

endpackage

[design/sha1s_sched.sv]
// Message block buffer and sliding sixteen-word message schedule.
module sha1s_sched
    import sha1s_pkg::*;
(
    input  logic             clk,
    input  sched_ctrl_t      ctrl,
    output logic [WordW-1:0] w
);

    logic [WordW-1:0] win_reg  [NumSched];
    logic [WordW-1:0] win_next [NumSched];
    logic [WordW-1:0] mix;

    // Tap 0 holds W[t-16]; taps 2, 8 and 13 give W[t-14], W[t-8] and W[t-3].
    assign mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w   = ctrl.early ? win_reg[0] : {mix[WordW-2:0], mix[WordW-1]};

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.step)
        begin
            for (int i = 0; i < NumSched - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[NumSched - 1] = w;
        end
        else if (ctrl.we)
        begin
            win_next[ctrl.pos[PosW-1:2]][{~ctrl.pos[1:0], 3'b000} +: ByteW] = ctrl.data;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

[design/sha1s_round.sv]
// Shared SHA-1 round unit with working variables and chaining words.
module sha1s_round
    import sha1s_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  round_ctrl_t                       ctrl,
    input  logic [WordW-1:0]                  w,
    output logic [NumChain-1:0][WordW-1:0]    chain
);

    logic [NumChain-1:0][WordW-1:0] work_reg;
    logic [NumChain-1:0][WordW-1:0] work_next;
    logic [NumChain-1:0][WordW-1:0] chain_reg;
    logic [NumChain-1:0][WordW-1:0] chain_next;

    logic [WordW-1:0] a, b, c, d, e;
    logic [WordW-1:0] f, k, t;

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];

    always_comb
    begin
        unique case (ctrl.phase)
            PH_CHOOSE:
            begin
                f = d ^ (b & (c ^ d));
                k = K0;
            end
            PH_PARITY_A:
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            PH_MAJORITY:
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            default:
            begin
                f = b ^ c ^ d;
                k = K3;
            end
        endcase
    end

    assign t = {a[WordW-6:0], a[WordW-1:WordW-5]} + f + e + k + w;

    always_comb
    begin
        work_next = work_reg;
        if (ctrl.load)
        begin
            work_next = chain_reg;
        end
        else if (ctrl.step)
        begin
            work_next[0] = t;
            work_next[1] = a;
            work_next[2] = {b[1:0], b[WordW-1:2]};
            work_next[3] = c;
            work_next[4] = d;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.restore)
        begin
            chain_next = IvWords;
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < NumChain; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= IvWords;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

[design/sha1_stream_hash.sv]
// Timing: a message byte that neither completes a block nor ends the message is taken
// without holding off the next request. The byte that completes a 64-byte block holds off
// requests while 80 rounds run through the single round unit and the result is folded into the chain.
// An end request pads one byte per cycle up to the end of the block, runs one or two
// blocks, then offers the five digest words one per cycle while the output is not stalled.
// Reset (asynchronous, active low) clears control, the byte count and loads the IV.
module sha1_stream_hash
    import sha1s_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Sequencer state and message bookkeeping.
    state_t              state_reg,     state_next;
    logic [RoundW-1:0]   round_reg,     round_next;
    logic [CountW-1:0]   count_reg,     count_next;
    logic [PosW-1:0]     pad_pos_reg,   pad_pos_next;
    logic                pad_first_reg, pad_first_next;
    logic                len_here_reg,  len_here_next;
    logic                final_reg,     final_next;
    logic                pad_pend_reg,  pad_pend_next;
    logic [IdxW-1:0]     word_idx_reg,  word_idx_next;

    // Output register, so the last digest word can wait without blocking the request side.
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg,       rsp_next;

    logic                accept;
    logic [PosW-1:0]     fill;
    logic                block_start;
    logic                rsp_load;
    logic                digest_done;
    logic [PosW-1:0]     pad_start;
    logic [LenW-1:0]     len_bits;
    logic [ByteW-1:0]    pad_byte;

    sched_ctrl_t                    sched_ctrl;
    round_ctrl_t                    round_ctrl;
    logic [WordW-1:0]               w;
    logic [NumChain-1:0][WordW-1:0] chain;

    assign accept      = req_valid && !req_stall;
    assign fill        = count_reg[PosW-1:0];
    // A block is started by the byte that fills position 63 or by the last padding byte.
    assign block_start = (state_reg == ST_IDLE && accept && req.byte_valid && fill == LastPos)
                      || (state_reg == ST_PAD && pad_pos_reg == LastPos);
    assign rsp_load    = (state_reg == ST_EMIT) && (!rsp_valid_reg || !rsp_stall);
    assign digest_done = rsp_load && (word_idx_reg == LastIdx);
    assign pad_start   = fill + PosW'(req.byte_valid);

    // The length field is the bit count, eight times the byte count, big-endian.
    assign len_bits = {count_reg, 3'b000};

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PadByte;
        end
        else if (len_here_reg && pad_pos_reg >= LenPos)
        begin
            pad_byte = len_bits[{~pad_pos_reg[2:0], 3'b000} +: ByteW];
        end
        else
        begin
            pad_byte = '0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (block_start)
                begin
                    state_next = ST_ROUND;
                end
                else if (accept && req.end_of_message)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LastRound)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (final_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (pad_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (pad_pos_reg == LastPos)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (digest_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        req_stall          = (state_reg != ST_IDLE);

        sched_ctrl.we      = 1'b0;
        sched_ctrl.pos     = fill;
        sched_ctrl.data    = req.data_byte;
        sched_ctrl.step    = (state_reg == ST_ROUND);
        sched_ctrl.early   = (round_reg < EarlyLimit);

        round_ctrl.load    = block_start;
        round_ctrl.step    = (state_reg == ST_ROUND);
        round_ctrl.fold    = (state_reg == ST_FOLD);
        round_ctrl.restore = digest_done;
        if (round_reg < RoundW'(20))
        begin
            round_ctrl.phase = PH_CHOOSE;
        end
        else if (round_reg < RoundW'(40))
        begin
            round_ctrl.phase = PH_PARITY_A;
        end
        else if (round_reg < RoundW'(60))
        begin
            round_ctrl.phase = PH_MAJORITY;
        end
        else
        begin
            round_ctrl.phase = PH_PARITY_B;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                sched_ctrl.we = accept && req.byte_valid;
            end
            ST_PAD:
            begin
                sched_ctrl.we   = 1'b1;
                sched_ctrl.pos  = pad_pos_reg;
                sched_ctrl.data = pad_byte;
            end
            default:
            begin
                sched_ctrl.we = 1'b0;
            end
        endcase
    end

    // Next values of the bookkeeping and output registers.
    always_comb
    begin
        round_next     = round_reg;
        count_next     = count_reg;
        pad_pos_next   = pad_pos_reg;
        pad_first_next = pad_first_reg;
        len_here_next  = len_here_reg;
        final_next     = final_reg;
        pad_pend_next  = pad_pend_reg;
        word_idx_next  = word_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.byte_valid)
                    begin
                        count_next = count_reg + CountW'(1);
                    end
                    if (block_start)
                    begin
                        // The byte closes a block; padding, if asked for, starts afresh.
                        final_next     = 1'b0;
                        pad_pend_next  = req.end_of_message;
                        pad_pos_next   = '0;
                        pad_first_next = 1'b1;
                        len_here_next  = 1'b1;
                    end
                    else if (req.end_of_message)
                    begin
                        pad_pos_next   = pad_start;
                        pad_first_next = 1'b1;
                        len_here_next  = (pad_start < LenPos);
                    end
                end
            end
            ST_ROUND:
            begin
                round_next = (round_reg == LastRound) ? '0 : round_reg + RoundW'(1);
            end
            ST_PAD:
            begin
                pad_pos_next   = pad_pos_reg + PosW'(1);
                pad_first_next = 1'b0;
                if (pad_pos_reg == LastPos)
                begin
                    // Without room for the length, a second padded block follows.
                    final_next    = len_here_reg;
                    pad_pend_next = !len_here_reg;
                    len_here_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.digest_word = chain[word_idx_reg];
                    rsp_next.word_index  = word_idx_reg;
                    rsp_next.last_word   = (word_idx_reg == LastIdx);
                    if (digest_done)
                    begin
                        word_idx_next = '0;
                        count_next    = '0;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg + IdxW'(1);
                    end
                end
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            count_reg     <= '0;
            pad_pos_reg   <= '0;
            pad_first_reg <= 1'b0;
            len_here_reg  <= 1'b0;
            final_reg     <= 1'b0;
            pad_pend_reg  <= 1'b0;
            word_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            count_reg     <= count_next;
            pad_pos_reg   <= pad_pos_next;
            pad_first_reg <= pad_first_next;
            len_here_reg  <= len_here_next;
            final_reg     <= final_next;
            pad_pend_reg  <= pad_pend_next;
            word_idx_reg  <= word_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sha1s_sched u_sched (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w    (w)
    );

    sha1s_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (round_ctrl),
        .w     (w),
        .chain (chain)
    );

endmodule

[design/sha1s_checker.sv]
// Port-level checker for the SHA-1 stream hash, bound to the top level.
module sha1s_checker
    import sha1s_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled digest word stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("digest word changed while stalled");

    // Only the word with the final index carries the last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.last_word == (rsp.word_index == LastIdx)))
        else $error("last mark does not match word index");

    // Digest words follow one another without gaps until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp.last_word |=>
            rsp_valid && (rsp.word_index == $past(rsp.word_index) + IdxW'(1)))
        else $error("digest words out of sequence");

    // An accepted end request always holds off the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.end_of_message |=> req_stall)
        else $error("request taken while message is being finished");

endmodule

bind sha1_stream_hash sha1s_checker u_sha1s_checker (.*);
